FILE: hw/rtl/prefixed_uint64_literal_parser_defines.svh
// Assertion macros for the prefixed uint64 literal parser.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef PREFIXED_UINT64_LITERAL_PARSER_DEFINES_SVH
`define PREFIXED_UINT64_LITERAL_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PLUP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define PLUP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PLUP_ASSERT_IMPLY(label, ante, cons)
`define PLUP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hw/rtl/plup_pkg.sv
// Shared types and constants of the prefixed uint64 literal parser.
// No dependencies.
`timescale 1ns / 1ps

package plup_pkg;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_ZERO   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_SUFFIX = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_OCT = 2'd2,
        BASE_BIN = 2'd3
    } base_t;

    // Error kinds double as the status codes of a result.
    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_OVF  = 2'd1,
        ERR_SYN  = 2'd2
    } err_t;

    typedef struct packed {
        phase_t      phase;
        base_t       base;
        logic [63:0] acc;
        err_t        err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase: PH_START,
        base:  BASE_DEC,
        acc:   64'd0,
        err:   ERR_NONE
    };

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_O  = 8'h6f;
    localparam logic [7:0] CH_UP_O  = 8'h4f;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_UP_U  = 8'h55;

    // Largest accumulator that can still be multiplied by the base.
    localparam logic [63:0] LIMIT_HEX = 64'h0FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_OCT = 64'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_BIN = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_DEC = 64'h1999_9999_9999_9999;

endpackage

FILE: hw/rtl/plup_mac.sv
// Digit decode and shift-add multiply-accumulate with overflow detection.
// Depends on plup_pkg.
`timescale 1ns / 1ps

module plup_mac
(
    input  plup_pkg::base_t base,
    input  logic [63:0]     acc,
    input  logic [7:0]      ch,
    output logic            digit_ok,
    output logic            ovf,
    output logic [63:0]     sum
);

    logic [4:0]  digit;
    logic [4:0]  radix;
    logic [63:0] limit;
    logic [63:0] product;
    logic [64:0] wide_sum;

    // Hex-aware digit value; 16 marks a non-digit.
    always_comb
    begin
        if (ch >= plup_pkg::CH_ZERO && ch <= plup_pkg::CH_NINE)
        begin
            digit = 5'(ch - plup_pkg::CH_ZERO);
        end
        else if (ch >= plup_pkg::CH_UP_A && ch <= plup_pkg::CH_UP_F)
        begin
            digit = 5'(ch - plup_pkg::CH_UP_A) + 5'd10;
        end
        else if (ch >= plup_pkg::CH_LO_A && ch <= plup_pkg::CH_LO_F)
        begin
            digit = 5'(ch - plup_pkg::CH_LO_A) + 5'd10;
        end
        else
        begin
            digit = 5'd16;
        end
    end

    always_comb
    begin
        unique case (base)
            plup_pkg::BASE_HEX:
            begin
                radix   = 5'd16;
                limit   = plup_pkg::LIMIT_HEX;
                product = {acc[59:0], 4'b0};
            end
            plup_pkg::BASE_OCT:
            begin
                radix   = 5'd8;
                limit   = plup_pkg::LIMIT_OCT;
                product = {acc[60:0], 3'b0};
            end
            plup_pkg::BASE_BIN:
            begin
                radix   = 5'd2;
                limit   = plup_pkg::LIMIT_BIN;
                product = {acc[62:0], 1'b0};
            end
            default:
            begin
                radix   = 5'd10;
                limit   = plup_pkg::LIMIT_DEC;
                product = {acc[60:0], 3'b0} + {acc[62:0], 1'b0};
            end
        endcase
    end

    // Product is exact whenever acc is within the limit; carry out flags the add.
    assign wide_sum = {1'b0, product} + {60'd0, digit};
    assign sum      = wide_sum[63:0];
    assign digit_ok = (digit < radix);
    assign ovf      = (acc > limit) || wide_sum[64];

endmodule

FILE: hw/rtl/plup_step.sv
// Next-state logic of the parser for one character item.
// Depends on plup_pkg and plup_mac.
`timescale 1ns / 1ps

module plup_step
(
    input  plup_pkg::parse_state_t cur,
    input  logic [7:0]             ch,
    input  logic                   has_char,
    output plup_pkg::parse_state_t nxt
);

    plup_pkg::base_t mac_base;
    logic [63:0]     mac_acc;
    logic            digit_ok;
    logic            ovf;
    logic [63:0]     sum;
    logic            is_u;
    logic            suffix_ok;

    always_comb
    begin
        unique case (cur.phase)
            plup_pkg::PH_ZERO:
            begin
                mac_base = plup_pkg::BASE_OCT;
                mac_acc  = 64'd0;
            end
            plup_pkg::PH_DIGITS:
            begin
                mac_base = cur.base;
                mac_acc  = cur.acc;
            end
            default:
            begin
                mac_base = plup_pkg::BASE_DEC;
                mac_acc  = cur.acc;
            end
        endcase
    end

    plup_mac u_mac
    (
        .base     (mac_base),
        .acc      (mac_acc),
        .ch       (ch),
        .digit_ok (digit_ok),
        .ovf      (ovf),
        .sum      (sum)
    );

    assign is_u      = (ch == plup_pkg::CH_LO_U) || (ch == plup_pkg::CH_UP_U);
    assign suffix_ok = is_u && ((mac_base == plup_pkg::BASE_DEC) ||
                                ((mac_base == plup_pkg::BASE_OCT) && (mac_acc == 64'd0)));

    always_comb
    begin
        logic take_digit;
        take_digit = 1'b0;
        nxt        = cur;
        if (has_char)
        begin
            unique case (cur.phase)
                plup_pkg::PH_ZERO:
                begin
                    nxt.phase = plup_pkg::PH_DIGITS;
                    if (ch == plup_pkg::CH_LO_X || ch == plup_pkg::CH_UP_X)
                    begin
                        nxt.base = plup_pkg::BASE_HEX;
                    end
                    else if (ch == plup_pkg::CH_LO_O || ch == plup_pkg::CH_UP_O)
                    begin
                        nxt.base = plup_pkg::BASE_OCT;
                    end
                    else if (ch == plup_pkg::CH_LO_B || ch == plup_pkg::CH_UP_B)
                    begin
                        nxt.base = plup_pkg::BASE_BIN;
                    end
                    else
                    begin
                        // leading zero counts as an octal digit
                        nxt.base   = plup_pkg::BASE_OCT;
                        nxt.acc    = 64'd0;
                        take_digit = 1'b1;
                    end
                end
                plup_pkg::PH_DIGITS:
                begin
                    take_digit = 1'b1;
                end
                plup_pkg::PH_SUFFIX:
                begin
                    nxt.phase = plup_pkg::PH_ERROR;
                    nxt.err   = plup_pkg::ERR_SYN;
                end
                plup_pkg::PH_ERROR:
                begin
                    nxt = cur;
                end
                default:
                begin
                    if (ch == plup_pkg::CH_ZERO)
                    begin
                        nxt.phase = plup_pkg::PH_ZERO;
                    end
                    else
                    begin
                        nxt.base   = plup_pkg::BASE_DEC;
                        nxt.phase  = plup_pkg::PH_DIGITS;
                        take_digit = 1'b1;
                    end
                end
            endcase

            if (take_digit)
            begin
                if (digit_ok)
                begin
                    if (ovf)
                    begin
                        nxt.phase = plup_pkg::PH_ERROR;
                        nxt.err   = plup_pkg::ERR_OVF;
                    end
                    else
                    begin
                        nxt.acc = sum;
                    end
                end
                else if (suffix_ok)
                begin
                    nxt.phase = plup_pkg::PH_SUFFIX;
                end
                else
                begin
                    nxt.phase = plup_pkg::PH_ERROR;
                    nxt.err   = plup_pkg::ERR_SYN;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/prefixed_uint64_literal_parser.sv
// Prefixed uint64 literal parser, one character per transaction.
// Each accepted item is held in the input register; a final item's result is then
// loaded into the result register. Throughput: one item per cycle while in_stall is low.
// in_stall rises only while a final item waits for a stalled result register.
// Reset (rst_n, async, active low) returns the parser to the start of a string
// and empties both the input and the result registers.
`timescale 1ns / 1ps
`include "prefixed_uint64_literal_parser_defines.svh"

module prefixed_uint64_literal_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        has_char,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] number,
    output logic [1:0]  status
);

    logic                   in_valid_reg;
    logic [7:0]             ch_reg;
    logic                   has_char_reg;
    logic                   last_reg;
    plup_pkg::parse_state_t state_reg;
    plup_pkg::parse_state_t state_next;
    plup_pkg::parse_state_t stepped;
    logic                   out_valid_reg;
    logic [63:0]            number_reg;
    logic [63:0]            number_next;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;
    logic                   out_free;
    logic                   advance;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ch_reg       <= ch;
            has_char_reg <= has_char;
            last_reg     <= last;
        end
    end

    plup_step u_step
    (
        .cur      (state_reg),
        .ch       (ch_reg),
        .has_char (has_char_reg),
        .nxt      (stepped)
    );

    always_comb
    begin
        state_next = stepped;
        if (last_reg)
        begin
            state_next = plup_pkg::STATE_RESET;
        end

        unique case (stepped.phase) inside
            plup_pkg::PH_ERROR:
            begin
                number_next = 64'd0;
                status_next = stepped.err;
            end
            plup_pkg::PH_DIGITS, plup_pkg::PH_SUFFIX:
            begin
                number_next = stepped.acc;
                status_next = plup_pkg::ERR_NONE;
            end
            default:
            begin
                number_next = 64'd0;
                status_next = plup_pkg::ERR_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plup_pkg::STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && last_reg;
        end
    end

    // Load the result only when a final item leaves the input register.
    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            number_reg <= number_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign number    = number_reg;
    assign status    = status_reg;

    `PLUP_ASSERT_IMPLY(a_error_has_kind, state_reg.phase == plup_pkg::PH_ERROR, state_reg.err != plup_pkg::ERR_NONE)
    `PLUP_ASSERT_NEXT(a_last_restarts, advance && last_reg, state_reg.phase == plup_pkg::PH_START && state_reg.acc == 64'd0)
    `PLUP_ASSERT_IMPLY(a_bad_status_zero, out_valid_reg && status_reg != plup_pkg::ERR_NONE, number_reg == 64'd0)
    `PLUP_ASSERT_IMPLY(a_mid_never_stalls, in_valid_reg && !last_reg, !in_stall)

endmodule

FILE: verif/prefixed_uint64_literal_parser_tb.sv
// Self-checking testbench for the prefixed uint64 literal parser: directed table, then
// random literals in all bases, checked against an in-bench parser model.
// Depends on plup_pkg and the prefixed_uint64_literal_parser top level.
`timescale 1ns / 1ps

module prefixed_uint64_literal_parser_tb;

    typedef struct packed {
        logic [7:0]     ch;
        logic           has_char;
        logic           last;
        logic           typed;
        logic [63:0]    exp_number;
        plup_pkg::err_t exp_status;
    } char_item_t;

    typedef struct packed {
        logic [63:0]    number;
        plup_pkg::err_t status;
    } parse_result_t;

    localparam int DIRECTED_ROWS = 27;
    localparam int TARGET_ITEMS = 1900;
    localparam int LONG_HOLD = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  ch;
    logic        has_char;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] number;
    logic [1:0]  status;

    // Typed expectations only where the value is obvious; other rows use the model.
    char_item_t directed_rows [DIRECTED_ROWS] = '{
        '{8'h00,             1'b0, 1'b1, 1'b1, 64'd0,  plup_pkg::ERR_NONE}, // empty string
        '{plup_pkg::CH_ZERO, 1'b1, 1'b1, 1'b1, 64'd0,  plup_pkg::ERR_NONE}, // lone zero
        '{plup_pkg::CH_ZERO, 1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE},
        '{plup_pkg::CH_LO_X, 1'b1, 1'b1, 1'b1, 64'd0,  plup_pkg::ERR_NONE}, // hex prefix only
        '{plup_pkg::CH_ZERO, 1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE},
        '{plup_pkg::CH_UP_O, 1'b1, 1'b1, 1'b1, 64'd0,  plup_pkg::ERR_NONE}, // octal prefix only
        '{plup_pkg::CH_ZERO, 1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE},
        '{plup_pkg::CH_UP_B, 1'b1, 1'b1, 1'b1, 64'd0,  plup_pkg::ERR_NONE}, // binary prefix only
        '{8'h00,             1'b1, 1'b1, 1'b1, 64'd0,  plup_pkg::ERR_SYN},  // byte zero
        '{8'hFF,             1'b1, 1'b1, 1'b1, 64'd0,  plup_pkg::ERR_SYN},
        '{8'h7a,             1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE}, // 'z' then a digit
        '{8'h35,             1'b1, 1'b1, 1'b1, 64'd0,  plup_pkg::ERR_SYN},  // first error wins
        '{8'h37,             1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE},
        '{plup_pkg::CH_LO_U, 1'b1, 1'b1, 1'b1, 64'd7,  plup_pkg::ERR_NONE}, // decimal, suffix
        '{plup_pkg::CH_ZERO, 1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE},
        '{plup_pkg::CH_UP_U, 1'b1, 1'b1, 1'b1, 64'd0,  plup_pkg::ERR_NONE}, // octal zero, suffix
        '{plup_pkg::CH_LO_U, 1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE},
        '{plup_pkg::CH_UP_U, 1'b1, 1'b1, 1'b1, 64'd0,  plup_pkg::ERR_SYN},  // second suffix
        '{8'h35,             1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE},
        '{8'h00,             1'b0, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE}, // no char: dropped
        '{8'h00,             1'b0, 1'b1, 1'b1, 64'd5,  plup_pkg::ERR_NONE}, // no char ends it
        '{plup_pkg::CH_ZERO, 1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE},
        '{plup_pkg::CH_LO_X, 1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE},
        '{plup_pkg::CH_UP_F, 1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE},
        '{plup_pkg::CH_LO_A, 1'b1, 1'b1, 1'b1, 64'hFA, plup_pkg::ERR_NONE}, // mixed-case hex
        '{plup_pkg::CH_ZERO, 1'b1, 1'b0, 1'b0, 64'd0,  plup_pkg::ERR_NONE},
        '{8'h38,             1'b1, 1'b1, 1'b1, 64'd0,  plup_pkg::ERR_SYN}   // 8 after a zero
    };

    char_item_t    text_q[$];
    parse_result_t pending_results[$];

    // Parser model state
    plup_pkg::phase_t p_phase = plup_pkg::PH_START;
    plup_pkg::base_t  p_base = plup_pkg::BASE_DEC;
    logic [63:0]      p_acc = 64'd0;
    plup_pkg::err_t   p_err = plup_pkg::ERR_NONE;

    int  mismatches = 0;
    int  text_items = 0;
    int  items_sent = 0;
    int  strings_ok = 0;
    int  strings_ovf = 0;
    int  strings_syn = 0;
    int  results_seen = 0;
    int  long_holds = 0;
    bit  send_quiet = 1'b0;
    bit  recv_quiet = 1'b0;
    bit  hold_pending = 1'b0;

    prefixed_uint64_literal_parser i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .has_char  (has_char),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .number    (number),
        .status    (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        end
    endtask

    function automatic logic [4:0] base_radix(input plup_pkg::base_t b);
        begin
            case (b)
                plup_pkg::BASE_HEX: return 5'd16;
                plup_pkg::BASE_OCT: return 5'd8;
                plup_pkg::BASE_BIN: return 5'd2;
                default:            return 5'd10;
            endcase
        end
    endfunction

    // Hex-aware digit value; 16 marks a non-digit
    function automatic logic [4:0] glyph_value(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd16;
            if (c >= plup_pkg::CH_ZERO && c <= plup_pkg::CH_NINE)
                t = c - plup_pkg::CH_ZERO;
            else if (c >= plup_pkg::CH_UP_A && c <= plup_pkg::CH_UP_F)
                t = c - plup_pkg::CH_UP_A + 8'd10;
            else if (c >= plup_pkg::CH_LO_A && c <= plup_pkg::CH_LO_F)
                t = c - plup_pkg::CH_LO_A + 8'd10;
            return t[4:0];
        end
    endfunction

    function automatic logic [7:0] glyph_of(input logic [3:0] d);
        logic [7:0] letter_a;
        begin
            if (d < 4'd10)
                return plup_pkg::CH_ZERO + 8'(d);
            letter_a = ($urandom_range(0, 1) != 0) ? plup_pkg::CH_UP_A : plup_pkg::CH_LO_A;
            return letter_a + 8'(d) - 8'd10;
        end
    endfunction

    task automatic absorb_digit(input logic [7:0] c);
        logic [4:0]  d;
        logic [4:0]  r;
        logic [68:0] prod;
        logic [64:0] sum;
        begin
            d = glyph_value(c);
            r = base_radix(p_base);
            if (d < r)
            begin
                // a carry out of bit 63 on either step is an overflow
                prod = {5'd0, p_acc} * 69'(r);
                if (prod[68:64] != 5'd0)
                begin
                    p_phase = plup_pkg::PH_ERROR;
                    p_err = plup_pkg::ERR_OVF;
                end
                else
                begin
                    sum = {1'b0, prod[63:0]} + 65'(d);
                    if (sum[64])
                    begin
                        p_phase = plup_pkg::PH_ERROR;
                        p_err = plup_pkg::ERR_OVF;
                    end
                    else
                        p_acc = sum[63:0];
                end
            end
            else if ((c == plup_pkg::CH_LO_U || c == plup_pkg::CH_UP_U) &&
                     (p_base == plup_pkg::BASE_DEC ||
                      (p_base == plup_pkg::BASE_OCT && p_acc == 64'd0)))
                p_phase = plup_pkg::PH_SUFFIX;
            else
            begin
                p_phase = plup_pkg::PH_ERROR;
                p_err = plup_pkg::ERR_SYN;
            end
        end
    endtask

    task automatic take_char(input logic [7:0] c);
        begin
            case (p_phase)
                plup_pkg::PH_ZERO:
                begin
                    p_phase = plup_pkg::PH_DIGITS;
                    if (c == plup_pkg::CH_LO_X || c == plup_pkg::CH_UP_X)
                        p_base = plup_pkg::BASE_HEX;
                    else if (c == plup_pkg::CH_LO_O || c == plup_pkg::CH_UP_O)
                        p_base = plup_pkg::BASE_OCT;
                    else if (c == plup_pkg::CH_LO_B || c == plup_pkg::CH_UP_B)
                        p_base = plup_pkg::BASE_BIN;
                    else
                    begin
                        // the leading zero stays as an octal digit
                        p_base = plup_pkg::BASE_OCT;
                        p_acc = 64'd0;
                        absorb_digit(c);
                    end
                end
                plup_pkg::PH_DIGITS:
                    absorb_digit(c);
                plup_pkg::PH_SUFFIX:
                begin
                    p_phase = plup_pkg::PH_ERROR;
                    p_err = plup_pkg::ERR_SYN;
                end
                plup_pkg::PH_ERROR:
                    ;
                default:
                begin
                    if (c == plup_pkg::CH_ZERO)
                        p_phase = plup_pkg::PH_ZERO;
                    else
                    begin
                        p_base = plup_pkg::BASE_DEC;
                        p_phase = plup_pkg::PH_DIGITS;
                        absorb_digit(c);
                    end
                end
            endcase
        end
    endtask

    task automatic advance_parser(input char_item_t it, output bit fin,
                                  output parse_result_t res);
        begin
            if (it.has_char)
                take_char(it.ch);
            fin = it.last;
            res = '{64'd0, plup_pkg::ERR_NONE};
            if (it.last)
            begin
                if (p_phase == plup_pkg::PH_ERROR)
                    res.status = p_err;
                else if (p_phase == plup_pkg::PH_DIGITS || p_phase == plup_pkg::PH_SUFFIX)
                    res.number = p_acc;
                p_phase = plup_pkg::PH_START;
                p_base = plup_pkg::BASE_DEC;
                p_acc = 64'd0;
                p_err = plup_pkg::ERR_NONE;
            end
        end
    endtask

    // Build one random literal, mostly well formed, and queue its characters
    task automatic add_literal();
        logic [7:0]  txt[$];
        logic [7:0]  digs[$];
        logic [63:0] v;
        logic [63:0] rr;
        logic [63:0] rem;
        int          kind;
        int          shape;
        int          radix;
        int          pos;
        char_item_t  it;
        begin
            kind = $urandom_range(0, 19);
            if (kind < 2)
            begin
                repeat ($urandom_range(1, 6))
                    txt.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                shape = $urandom_range(0, 4);
                case (shape) inside
                    0:       radix = 10;
                    1:       radix = 16;
                    2, 3:    radix = 8;
                    default: radix = 2;
                endcase
                rr = 64'(radix);
                case ($urandom_range(0, 9)) inside
                    0:       v = 64'd0;
                    1:       v = '1;
                    2, 3:    v = 64'($urandom_range(0, 999));
                    default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                endcase
                // push toward the top of the range, then add digits that may overflow
                if (kind < 5)
                    v = (kind == 2) ? '1 : '1 / rr;
                case (shape)
                    1:
                    begin
                        txt.push_back(plup_pkg::CH_ZERO);
                        txt.push_back(($urandom_range(0, 1) != 0) ?
                                      plup_pkg::CH_UP_X : plup_pkg::CH_LO_X);
                    end
                    2:
                    begin
                        txt.push_back(plup_pkg::CH_ZERO);
                        txt.push_back(($urandom_range(0, 1) != 0) ?
                                      plup_pkg::CH_UP_O : plup_pkg::CH_LO_O);
                    end
                    3:
                        txt.push_back(plup_pkg::CH_ZERO);
                    4:
                    begin
                        txt.push_back(plup_pkg::CH_ZERO);
                        txt.push_back(($urandom_range(0, 1) != 0) ?
                                      plup_pkg::CH_UP_B : plup_pkg::CH_LO_B);
                    end
                    default:
                        ;
                endcase
                do
                begin
                    rem = v % rr;
                    digs.push_front(glyph_of(rem[3:0]));
                    v = v / rr;
                end
                while (v != 64'd0);
                foreach (digs[k])
                    txt.push_back(digs[k]);
                if (kind < 5)
                begin
                    repeat ($urandom_range(1, 2))
                        txt.push_back(glyph_of(4'($urandom_range(0, radix - 1))));
                end
                if ($urandom_range(0, 3) == 0)
                    txt.push_back(($urandom_range(0, 1) != 0) ?
                                  plup_pkg::CH_UP_U : plup_pkg::CH_LO_U);
                if (kind >= 5 && kind < 8)
                begin
                    pos = $urandom_range(0, txt.size() - 1);
                    if ($urandom_range(0, 1) != 0)
                        txt[pos] = 8'($urandom_range(0, 255));
                    else
                        txt.insert(pos, 8'($urandom_range(0, 255)));
                end
                if (kind == 19)
                    txt.delete();
            end
            foreach (txt[k])
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    it = '{8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 64'd0,
                           plup_pkg::ERR_NONE};
                    text_q.push_back(it);
                end
                it = '{txt[k], 1'b1, 1'b0, 1'b0, 64'd0, plup_pkg::ERR_NONE};
                text_q.push_back(it);
                text_items++;
            end
            if (txt.size() == 0 || $urandom_range(0, 9) == 0)
            begin
                it = '{8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 64'd0,
                       plup_pkg::ERR_NONE};
                text_q.push_back(it);
                text_items++;
            end
            else
                text_q[$].last = 1'b1;
        end
    endtask

    task automatic send_item(input char_item_t it);
        int            gap;
        bit            fin;
        parse_result_t res;
        begin
            if ($urandom_range(0, 39) == 0)
                send_quiet = !send_quiet;
            gap = send_quiet ? 0 : $urandom_range(0, 10);
            @(negedge clk);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            ch <= it.ch;
            has_char <= it.has_char;
            last <= it.last;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            items_sent++;
            advance_parser(it, fin, res);
            if (fin)
            begin
                if (it.typed)
                begin
                    res.number = it.exp_number;
                    res.status = it.exp_status;
                end
                pending_results.push_back(res);
                case (res.status)
                    plup_pkg::ERR_OVF: strings_ovf++;
                    plup_pkg::ERR_SYN: strings_syn++;
                    default:           strings_ok++;
                endcase
            end
        end
    endtask

    task automatic check_result();
        parse_result_t want;
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result number=%h status=%0d",
                                          number, status));
            else
            begin
                want = pending_results.pop_front();
                if (number !== want.number)
                    report_mismatch($sformatf("number %h, expected %h", number, want.number));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            end
        end
    endtask

    // Result side: random stall before each transaction, one long hold on request
    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                recv_quiet = !recv_quiet;
            gap = recv_quiet ? 0 : $urandom_range(0, 10);
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                long_holds++;
                gap = LONG_HOLD;
            end
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            check_result();
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        ch = 8'd0;
        has_char = 1'b0;
        last = 1'b0;
        while (text_items < TARGET_ITEMS - DIRECTED_ROWS)
            add_literal();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(directed_rows[i]);
        foreach (text_q[i])
        begin
            // starve the result side while characters keep coming
            if (i == 400)
                hold_pending = 1'b1;
            send_item(text_q[i]);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d input transactions and %0d literals", items_sent,
                 strings_ok + strings_ovf + strings_syn);
        $display("  (%0d ok, %0d overflow, %0d syntax); %0d results, %0d long output hold(s)",
                 strings_ok, strings_ovf, strings_syn, results_seen, long_holds);
        if (mismatches == 0)
            $display("prefixed_uint64_literal_parser_tb passed");
        else
            $display("prefixed_uint64_literal_parser_tb failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("prefixed_uint64_literal_parser_tb failed");
        $finish;
    end

endmodule
